FILE: rtl/core/mi3_pkg.sv
// Package holding the types, widths and helper functions of the 3x3 inverse block.
package mi3_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = 32;
   localparam int COF_W     = 64;
   localparam int DET_W     = 98;
   localparam int MAG_W     = 97;
   localparam int NUM_W     = MAG_W + 2*FRAC_BITS + 2;
   localparam int DIV_W     = MAG_W + 1;
   localparam int QUO_W     = NUM_W;
   localparam int NUM_LANES = 9;

   typedef struct packed {
      logic signed [ELEM_W-1:0] m_r0c0;
      logic signed [ELEM_W-1:0] m_r0c1;
      logic signed [ELEM_W-1:0] m_r0c2;
      logic signed [ELEM_W-1:0] m_r1c0;
      logic signed [ELEM_W-1:0] m_r1c1;
      logic signed [ELEM_W-1:0] m_r1c2;
      logic signed [ELEM_W-1:0] m_r2c0;
      logic signed [ELEM_W-1:0] m_r2c1;
      logic signed [ELEM_W-1:0] m_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] inv_r0c0;
      logic signed [ELEM_W-1:0] inv_r0c1;
      logic signed [ELEM_W-1:0] inv_r0c2;
      logic signed [ELEM_W-1:0] inv_r1c0;
      logic signed [ELEM_W-1:0] inv_r1c1;
      logic signed [ELEM_W-1:0] inv_r1c2;
      logic signed [ELEM_W-1:0] inv_r2c0;
      logic signed [ELEM_W-1:0] inv_r2c1;
      logic signed [ELEM_W-1:0] inv_r2c2;
      logic signed [ELEM_W-1:0] determinant;
      logic                     singular;
      logic                     saturated;
   } rsp_type;

   // Per-lane result handed to the merging stage.
   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              sat;
   } lane_out_type;

   // Saturate a sign-magnitude quotient to a 32-bit two's complement value.
   function automatic lane_out_type clip_q(input logic neg, input logic [QUO_W-1:0] mag);
      lane_out_type r;
      logic [QUO_W-1:0] lim;
      logic [QUO_W-1:0] m;
      lim = neg ? QUO_W'(64'h8000_0000) : QUO_W'(64'h7FFF_FFFF);
      m   = mag;
      r.sat = 1'b0;
      if (mag > lim) begin
         r.sat = 1'b1;
         m = lim;
      end
      r.value = neg ? ELEM_W'(~m[ELEM_W-1:0] + 1'b1) : m[ELEM_W-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/core/mi3_front.sv
// Front end: nine cofactor lanes and the determinant, built over a pipeline of registered stages.
module mi3_front
   import mi3_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  req_type                         in_data,
   output logic                            out_valid,
   output logic signed [COF_W-1:0]         out_cof [NUM_LANES],
   output logic                            out_dneg,
   output logic [MAG_W-1:0]                out_dmag,
   output logic                            out_zero
);

   logic signed [ELEM_W-1:0] e [9];
   logic signed [COF_W-1:0]  pa_in [NUM_LANES];
   logic signed [COF_W-1:0]  pb_in [NUM_LANES];
   logic signed [COF_W-1:0]  pa_ff [NUM_LANES];
   logic signed [COF_W-1:0]  pb_ff [NUM_LANES];
   logic signed [ELEM_W-1:0] r0_ff [3];
   logic                     v1_ff, v2_ff;
   logic signed [COF_W-1:0]  cof_ff [NUM_LANES];
   logic signed [COF_W-1:0]  cof_in [NUM_LANES];
   logic signed [DET_W-1:0]  det_ff;
   logic                     v3_ff;

   assign e[0] = in_data.m_r0c0; assign e[1] = in_data.m_r0c1; assign e[2] = in_data.m_r0c2;
   assign e[3] = in_data.m_r1c0; assign e[4] = in_data.m_r1c1; assign e[5] = in_data.m_r1c2;
   assign e[6] = in_data.m_r2c0; assign e[7] = in_data.m_r2c1; assign e[8] = in_data.m_r2c2;

   // Stage one: the eighteen 32x32 products of the cofactors.
   always_comb begin
      pa_in[0] = e[4]*e[8]; pb_in[0] = e[5]*e[7];
      pa_in[1] = e[2]*e[7]; pb_in[1] = e[1]*e[8];
      pa_in[2] = e[1]*e[5]; pb_in[2] = e[2]*e[4];
      pa_in[3] = e[5]*e[6]; pb_in[3] = e[3]*e[8];
      pa_in[4] = e[0]*e[8]; pb_in[4] = e[2]*e[6];
      pa_in[5] = e[2]*e[3]; pb_in[5] = e[0]*e[5];
      pa_in[6] = e[3]*e[7]; pb_in[6] = e[4]*e[6];
      pa_in[7] = e[1]*e[6]; pb_in[7] = e[0]*e[7];
      pa_in[8] = e[0]*e[4]; pb_in[8] = e[1]*e[3];
   end

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      r0_ff <= '{e[0], e[1], e[2]};
   end

   // Stage two: cofactor differences, exact in 64 bits.
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) cof_in[i] = pa_ff[i] - pb_ff[i];
   end

   // Stage three: row 0 times its cofactors (Laplace expansion equals Sarrus exactly).
   logic signed [ELEM_W-1:0] r0b_ff [3];
   always_ff @(posedge clock) begin
      cof_ff <= cof_in;
      r0b_ff <= r0_ff;
   end

   // Each 32x64 product is split into a low half (unsigned cofactor bits) and a signed
   // high half, so that every multiplier stays about 32x32 wide.
   logic signed [COF_W-1:0] csel [3];
   logic signed [COF_W:0]   plo_in [3];
   logic signed [COF_W-1:0] phi_in [3];
   assign csel[0] = cof_ff[0];
   assign csel[1] = cof_ff[3];
   assign csel[2] = cof_ff[6];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         plo_in[k] = r0b_ff[k] * $signed({1'b0, csel[k][ELEM_W-1:0]});
         phi_in[k] = r0b_ff[k] * $signed(csel[k][COF_W-1:ELEM_W]);
      end
   end

   logic signed [COF_W:0]   plo_ff [3];
   logic signed [COF_W-1:0] phi_ff [3];
   logic signed [COF_W-1:0] cof2_ff [NUM_LANES];
   always_ff @(posedge clock) begin
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      cof2_ff <= cof_ff;
   end

   // Stage four: recombine the halves and add the three row terms.
   logic signed [DET_W-1:0] t_in [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         t_in[k] = (DET_W'(phi_ff[k]) <<< ELEM_W) + DET_W'(plo_ff[k]);
   end

   logic signed [COF_W-1:0] cof3_ff [NUM_LANES];
   always_ff @(posedge clock) begin
      det_ff  <= t_in[0] + t_in[1] + t_in[2];
      cof3_ff <= cof2_ff;
   end

   // Valid pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; out_valid <= 1'b0;
      end else begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; out_valid <= v3_ff;
      end
   end

   assign out_cof  = cof3_ff;
   assign out_dneg = det_ff[DET_W-1];
   assign out_dmag = MAG_W'(det_ff[DET_W-1] ? -det_ff : det_ff);
   assign out_zero = (det_ff == '0);

endmodule

FILE: rtl/core/mi3_lane.sv
// One inverse lane: a pipelined restoring divider giving the rounded quotient of one cofactor.
module mi3_lane
   import mi3_pkg::*;
(
   input  logic                    clock,
   input  logic signed [COF_W-1:0] cof,
   input  logic [MAG_W-1:0]        dmag,
   input  logic                    dneg,
   output lane_out_type            result
);

   // Numerator is |cof| << (2F+1) plus |det|; divisor is 2|det|, giving round-half-away.
   logic [NUM_W-1:0] num_in;
   logic [DIV_W-1:0] div_in;
   logic             neg_in;
   logic [COF_W-1:0] mag;

   assign mag    = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
   assign num_in = (NUM_W'(mag) << (2*FRAC_BITS + 1)) + NUM_W'(dmag);
   assign div_in = {dmag, 1'b0};
   assign neg_in = cof[COF_W-1] ^ dneg;

   logic [DIV_W:0]   rem_ff [NUM_W+1];
   logic [NUM_W-1:0] num_ff [NUM_W+1];
   logic [DIV_W-1:0] div_ff [NUM_W+1];
   logic             neg_ff [NUM_W+1];

   // One quotient bit per stage; the numerator register shifts quotient bits in from the right.
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      num_ff[0] <= num_in;
      div_ff[0] <= div_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DIV_W:0] trial;
      logic           ge;
      assign trial = {rem_ff[s][DIV_W-1:0], num_ff[s][NUM_W-1]};
      assign ge    = trial >= {1'b0, div_ff[s]};
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= ge ? trial - {1'b0, div_ff[s]} : trial;
         num_ff[s+1] <= {num_ff[s][NUM_W-2:0], ge};
         div_ff[s+1] <= div_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   logic [QUO_W-1:0] q;
   assign q = num_ff[NUM_W];

   always_ff @(posedge clock) begin
      result <= clip_q(neg_ff[NUM_W] && (q != '0), q);
   end

endmodule

FILE: rtl/core/mi3_merge.sv
// Merging stage: gathers the lane quotients, rounds the determinant and forms the result.
module mi3_merge
   import mi3_pkg::*;
(
   input  logic              clock,
   input  lane_out_type      lane [NUM_LANES],
   input  logic              dneg,
   input  logic [MAG_W-1:0]  dmag,
   input  logic              zero,
   output rsp_type           rsp
);

   logic [MAG_W:0]  rounded;
   logic [QUO_W-1:0] dq;
   lane_out_type    dres;
   logic            sat_any;
   rsp_type         rsp_in;

   // Determinant: round the magnitude to nearest, ties away from zero, then saturate.
   assign rounded = ({1'b0, dmag} + ((MAG_W+1)'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
   assign dq      = QUO_W'(rounded);
   assign dres    = clip_q(dneg && (rounded != '0), dq);

   always_comb begin
      sat_any = dres.sat;
      for (int i = 0; i < NUM_LANES; i++) sat_any = sat_any | lane[i].sat;
      rsp_in.inv_r0c0    = lane[0].value;
      rsp_in.inv_r0c1    = lane[1].value;
      rsp_in.inv_r0c2    = lane[2].value;
      rsp_in.inv_r1c0    = lane[3].value;
      rsp_in.inv_r1c1    = lane[4].value;
      rsp_in.inv_r1c2    = lane[5].value;
      rsp_in.inv_r2c0    = lane[6].value;
      rsp_in.inv_r2c1    = lane[7].value;
      rsp_in.inv_r2c2    = lane[8].value;
      rsp_in.determinant = dres.value;
      rsp_in.singular    = zero;
      rsp_in.saturated   = sat_any;
      if (zero) begin
         rsp_in           = '0;
         rsp_in.singular  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp <= rsp_in;
   end

endmodule

FILE: rtl/core/matrix3_inverse_det_top.sv
// Pipeline: 4 front stages + NUM_W+2 divider stages + 1 merge stage.
// Throughput: one matrix per cycle; busy is never raised, since every lane is fully pipelined.
// The nine divider lanes each retire one quotient bit per stage, which sets the latency.
// Reset, synchronous and active high, clears the valid pipeline only.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module matrix3_inverse_det_top
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int LANE_LAT = NUM_W + 2;

   logic                    f_valid;
   logic signed [COF_W-1:0] f_cof [NUM_LANES];
   logic                    f_dneg;
   logic [MAG_W-1:0]        f_dmag;
   logic                    f_zero;
   lane_out_type            lane_res [NUM_LANES];

   assign busy = 1'b0;

   mi3_front u_front (
      .clock, .reset,
      .in_valid(start), .in_data(req_data),
      .out_valid(f_valid), .out_cof(f_cof), .out_dneg(f_dneg),
      .out_dmag(f_dmag), .out_zero(f_zero)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      mi3_lane u_lane (
         .clock, .cof(f_cof[i]), .dmag(f_dmag), .dneg(f_dneg), .result(lane_res[i])
      );
   end

   // Side channel delayed to match the divider lanes.
   logic             v_ff  [LANE_LAT];
   logic             dn_ff [LANE_LAT];
   logic             z_ff  [LANE_LAT];
   logic [MAG_W-1:0] dm_ff [LANE_LAT];
   logic             out_v_ff;

   always_ff @(posedge clock) begin
      dn_ff[0] <= f_dneg; z_ff[0] <= f_zero; dm_ff[0] <= f_dmag;
      for (int s = 1; s < LANE_LAT; s++) begin
         dn_ff[s] <= dn_ff[s-1]; z_ff[s] <= z_ff[s-1]; dm_ff[s] <= dm_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) v_ff[s] <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v_ff[0] <= f_valid;
         for (int s = 1; s < LANE_LAT; s++) v_ff[s] <= v_ff[s-1];
         out_v_ff <= v_ff[LANE_LAT-1];
      end
   end

   mi3_merge u_merge (
      .clock, .lane(lane_res), .dneg(dn_ff[LANE_LAT-1]), .dmag(dm_ff[LANE_LAT-1]),
      .zero(z_ff[LANE_LAT-1]), .rsp(rsp_data)
   );

   assign rsp_valid = out_v_ff;

`ifndef NO_ASSERTIONS
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> rsp_data.determinant == '0 && !rsp_data.saturated)
      else $error("singular result carries nonzero fields");
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe just after reset");
`endif

endmodule

FILE: tb/tb_matrix3_inverse_det_top.sv
// Self-checking testbench of the 3x3 matrix inverse and determinant block.
module tb_matrix3_inverse_det_top;
   import mi3_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_matrices[$];
   rsp_type expected_inverses[$];
   int      mismatch_count;
   int      send_idle_pct;

   matrix3_inverse_det_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Saturate a sign-magnitude value to 32 bits, noting any clipping.
   function automatic logic [31:0] clamp_word(input bit neg, input logic [255:0] mag,
                                              inout bit sat);
      logic [255:0] lim;
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
   endfunction

   // Adjugate inverse and determinant of one matrix, computed exactly, then rounded and saturated.
   function automatic rsp_type invert_matrix(input req_type m);
      rsp_type r;
      logic signed [31:0] a [9];
      logic signed [127:0] det;
      logic signed [63:0] cof [9];
      logic [255:0] dmag;
      logic [255:0] num;
      logic [255:0] quo;
      logic [31:0] vals [10];
      bit dneg;
      bit neg;
      bit sat;
      a[0] = m.m_r0c0; a[1] = m.m_r0c1; a[2] = m.m_r0c2;
      a[3] = m.m_r1c0; a[4] = m.m_r1c1; a[5] = m.m_r1c2;
      a[6] = m.m_r2c0; a[7] = m.m_r2c1; a[8] = m.m_r2c2;
      det = 128'(a[0]) * a[4] * a[8] + 128'(a[1]) * a[5] * a[6] + 128'(a[2]) * a[3] * a[7]
          - 128'(a[2]) * a[4] * a[6] - 128'(a[0]) * a[5] * a[7] - 128'(a[1]) * a[3] * a[8];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      dneg = det < 0;
      dmag = dneg ? 256'(-det) : 256'(det);
      cof[0] = 64'(a[4]) * a[8] - 64'(a[5]) * a[7];
      cof[1] = 64'(a[2]) * a[7] - 64'(a[1]) * a[8];
      cof[2] = 64'(a[1]) * a[5] - 64'(a[2]) * a[4];
      cof[3] = 64'(a[5]) * a[6] - 64'(a[3]) * a[8];
      cof[4] = 64'(a[0]) * a[8] - 64'(a[2]) * a[6];
      cof[5] = 64'(a[2]) * a[3] - 64'(a[0]) * a[5];
      cof[6] = 64'(a[3]) * a[7] - 64'(a[4]) * a[6];
      cof[7] = 64'(a[1]) * a[6] - 64'(a[0]) * a[7];
      cof[8] = 64'(a[0]) * a[4] - 64'(a[1]) * a[3];
      sat = 1'b0;
      // Round to nearest, ties away from zero, on magnitudes.
      for (int i = 0; i < 9; i++) begin
         neg = (cof[i] < 0) != dneg;
         num = cof[i] < 0 ? 256'(64'(-cof[i])) : 256'(cof[i]);
         num = (num << (2*FRAC_BITS + 1)) + dmag;
         quo = num / (dmag << 1);
         if (quo == 0) neg = 1'b0;
         vals[i] = clamp_word(neg, quo, sat);
      end
      quo = (dmag + (256'd1 << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
      vals[9] = clamp_word(dneg && quo != 0, quo, sat);
      r.inv_r0c0 = vals[0]; r.inv_r0c1 = vals[1]; r.inv_r0c2 = vals[2];
      r.inv_r1c0 = vals[3]; r.inv_r1c1 = vals[4]; r.inv_r1c2 = vals[5];
      r.inv_r2c0 = vals[6]; r.inv_r2c1 = vals[7]; r.inv_r2c2 = vals[8];
      r.determinant = vals[9];
      r.saturated = sat;
      return r;
   endfunction

   // Random element: mostly moderate values, sometimes full-width or extreme.
   function automatic logic [31:0] random_element();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3:       return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
         4:       return 32'($signed($urandom_range(0, 8)) - 4);
         default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      logic [31:0] e [9];
      for (int i = 0; i < 9; i++) e[i] = random_element();
      // Now and then make it singular by copying or negating a row.
      if ($urandom_range(0, 9) == 0) begin
         e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end else if ($urandom_range(0, 19) == 0) begin
         e[3] = -e[0]; e[4] = -e[1]; e[5] = -e[2];
      end
      m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      return m;
   endfunction

   // Driver: start a transaction whenever one is pending and the sender is not idling.
   // The accepted transaction leaves the queue first, so the head is always the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_inverses.push_back(invert_matrix(req_data));
            void'(pending_matrices.pop_front());
         end
         if ((!start || !busy) && pending_matrices.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_matrices[0];
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every result strobe is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", rsp_data);
         end else begin
            if (rsp_data !== expected_inverses[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %h actual %h", expected_inverses[0], rsp_data);
            end
            void'(expected_inverses.pop_front());
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      req_type m;
      logic [31:0] one;
      logic [31:0] ext [6];
      mismatch_count = 0;
      send_idle_pct  = 24;
      reset    = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, zero, scaled, extremes, singular and tiny determinants.
      one = 32'h0001_0000;
      ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, one};
      pending_matrices.push_back({one, 32'h0, 32'h0, 32'h0, one, 32'h0, 32'h0, 32'h0, one});
      pending_matrices.push_back('0);
      pending_matrices.push_back({-one, 32'h0, 32'h0, 32'h0, one << 1, 32'h0, 32'h0, 32'h0,
                                  one >> 1});
      foreach (ext[i]) begin
         pending_matrices.push_back({9{ext[i]}});
         pending_matrices.push_back({ext[i], 32'h0, 32'h0, 32'h0, ext[i], 32'h0, 32'h0,
                                     32'h0, ext[i]});
      end
      pending_matrices.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF});
      pending_matrices.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
                                  32'h1});
      pending_matrices.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h0, 32'h7FFF_FFFF});
      pending_matrices.push_back({one, one << 1, 32'h0, one << 1, one << 2, 32'h0, 32'h0,
                                  32'h0, one});

      // Random phases: sender idles at two rates, then no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 87 : 0;
         for (int i = 0; i < 567; i++) begin
            m = random_matrix();
            pending_matrices.push_back(m);
         end
         while (pending_matrices.size() > 0) @(posedge clock);
      end
      while (expected_inverses.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: matrix3_inverse_det_top.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_lane.sv
rtl/core/mi3_merge.sv
rtl/core/matrix3_inverse_det_top.sv
tb/tb_matrix3_inverse_det_top.sv
